// File: src/ssl_pkg.sv
// Package for the sorted set linked table: field widths, operation and
// status codes, controller state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ssl_pkg;

  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_WALK = 6'b000010,
    S_END  = 6'b000100,
    S_SCAN = 6'b001000,
    S_LINK = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

endpackage
`default_nettype wire

// File: src/ssl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ssl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/sorted_set_linked_table.sv
// Top level of the sorted set linked table: ascending linked list of signed
// values in a node table. Uses ssl_pkg and two ssl_ram instances.
//
//   channel  direction  ports                       handshake
//   in       input      in_kind, in_value           in_valid / in_stall
//   out      output     out_status                  out_valid / out_stall
//
// One item at a time: the list walk reads value and link RAM per node; an
// insert then scans used-map slots 1 to NODE_COUNT-1 and writes the links of
// the new node and, unless it is the new head, its predecessor. Reset clears
// the used map but for sentinel node 0, and head link, at once; no clearing
// pass. A held result does not block the next item from being accepted.
`timescale 1ns / 1ps
`default_nettype none
module sorted_set_linked_table #(
  parameter int NODE_COUNT = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ssl_pkg::KIND_W-1:0]    in_kind,
  input  wire logic signed [ssl_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ssl_pkg::STATUS_W-1:0]       out_status
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam logic [AW-1:0] LAST = AW'(NODE_COUNT - 1);

  ssl_pkg::state_t state_r, state_nxt;

  logic [ssl_pkg::KIND_W-1:0]        kind_r, kind_nxt;
  logic signed [ssl_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] prev_r, prev_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] next_r, next_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          found_r, found_nxt;
  logic [NODE_COUNT-1:0] used_r, used_nxt;
  logic [ssl_pkg::STATUS_W-1:0] res_r, res_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [ssl_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  logic [AW-1:0] rd_addr;
  logic signed [ssl_pkg::VALUE_W-1:0] val_q;
  logic [AW-1:0] link_q;
  logic          val_we;
  logic          link_we;
  logic [AW-1:0] link_waddr;
  logic [AW-1:0] link_wdata;
  logic          in_acc;

  ssl_ram #(.WIDTH(ssl_pkg::VALUE_W), .DEPTH(NODE_COUNT)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (idx_r),
    .wdata (val_r),
    .raddr (rd_addr),
    .rdata (val_q)
  );

  ssl_ram #(.WIDTH(AW), .DEPTH(NODE_COUNT)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (link_q)
  );

  assign in_stall   = (state_r != ssl_pkg::S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign rd_addr    = (state_r == ssl_pkg::S_IDLE) ? head_r : link_q;

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    val_nxt        = val_r;
    head_nxt       = head_r;
    prev_nxt       = prev_r;
    cur_nxt        = cur_r;
    next_nxt       = next_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    used_nxt       = used_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    val_we         = 1'b0;
    link_we        = 1'b0;
    link_waddr     = idx_r;
    link_wdata     = cur_r;
    case (state_r)
      ssl_pkg::S_IDLE: begin
        if (in_acc) begin
          kind_nxt  = in_kind;
          val_nxt   = in_value;
          prev_nxt  = '0;
          cur_nxt   = head_r;
          found_nxt = 1'b0;
          state_nxt = (head_r != '0) ? ssl_pkg::S_WALK : ssl_pkg::S_END;
        end
      end
      ssl_pkg::S_WALK: begin
        if (val_q == val_r) begin
          found_nxt = 1'b1;
          next_nxt  = link_q;
          state_nxt = ssl_pkg::S_END;
        end else if (val_q > val_r) begin
          state_nxt = ssl_pkg::S_END;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = link_q;
          if (link_q == '0) begin
            state_nxt = ssl_pkg::S_END;
          end
        end
      end
      ssl_pkg::S_END: begin
        state_nxt = ssl_pkg::S_RESP;
        case (kind_r)
          ssl_pkg::KIND_INSERT: begin
            if (found_r) begin
              res_nxt = ssl_pkg::ST_PRESENT;
            end else begin
              idx_nxt   = AW'(1);
              state_nxt = ssl_pkg::S_SCAN;
            end
          end
          ssl_pkg::KIND_DELETE: begin
            if (found_r) begin
              res_nxt        = ssl_pkg::ST_OK;
              used_nxt[cur_r] = 1'b0;
              if (prev_r == '0) begin
                head_nxt = next_r;
              end else begin
                link_we    = 1'b1;
                link_waddr = prev_r;
                link_wdata = next_r;
              end
            end else begin
              res_nxt = ssl_pkg::ST_MISSING;
            end
          end
          default: begin
            res_nxt = found_r ? ssl_pkg::ST_OK : ssl_pkg::ST_MISSING;
          end
        endcase
      end
      ssl_pkg::S_SCAN: begin
        if (!used_r[idx_r]) begin
          val_we          = 1'b1;
          link_we         = 1'b1;
          link_waddr      = idx_r;
          link_wdata      = cur_r;
          used_nxt[idx_r] = 1'b1;
          res_nxt         = ssl_pkg::ST_OK;
          if (prev_r == '0) begin
            head_nxt  = idx_r;
            state_nxt = ssl_pkg::S_RESP;
          end else begin
            state_nxt = ssl_pkg::S_LINK;
          end
        end else if (idx_r == LAST) begin
          res_nxt   = ssl_pkg::ST_FULL;
          state_nxt = ssl_pkg::S_RESP;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      ssl_pkg::S_LINK: begin
        link_we    = 1'b1;
        link_waddr = prev_r;
        link_wdata = idx_r;
        state_nxt  = ssl_pkg::S_RESP;
      end
      ssl_pkg::S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
          state_nxt      = ssl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ssl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssl_pkg::S_IDLE;
      head_r      <= '0;
      used_r      <= NODE_COUNT'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    val_r        <= val_nxt;
    prev_r       <= prev_nxt;
    cur_r        <= cur_nxt;
    next_r       <= next_nxt;
    idx_r        <= idx_nxt;
    found_r      <= found_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
  end

  a_sentinel_used: assert property (@(posedge clk) disable iff (!rst_n)
    used_r[0]) else $error("sentinel node marked free");

  a_head_used: assert property (@(posedge clk) disable iff (!rst_n)
    used_r[head_r]) else $error("head names a free node");

  a_walk_node: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ssl_pkg::S_WALK |-> cur_r != '0 && used_r[cur_r])
    else $error("walk reached null or free node");

  a_link_prev: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ssl_pkg::S_LINK |-> prev_r != '0 && used_r[idx_r])
    else $error("link write without predecessor or slot");

endmodule
`default_nettype wire
